/* design/hvn_pkg.sv */
// hvn_pkg: shared types and constants for the heightmap vertex normal block
// no dependencies; used by hvn_iter and heightmap_vertex_normals
`default_nettype none

package hvn_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_LENGTH = 1024;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_LENGTH);
  localparam int CNT_W      = 11;
  localparam int MEM_AW     = COL_W + 1;

  localparam logic [1:0] REG_GRID_WIDTH   = 2'd0;
  localparam logic [1:0] REG_GRID_LENGTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT_SCALE = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_DIFF,
    ST_TRI,
    ST_SQ,
    ST_ROOT_GO,
    ST_ROOT_WAIT,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_SUMSQ,
    ST_ROOT2_GO,
    ST_ROOT2_WAIT,
    ST_DIV2_GO,
    ST_DIV2_WAIT,
    ST_OUT
  } hvn_state_t;

  // one job for the shared root / divide unit
  typedef struct packed {
    logic        start;
    logic        is_root;
    logic [63:0] opa;
    logic [31:0] opd;
  } iter_cmd_t;

endpackage

`default_nettype wire

/* design/hvn_iter.sv */
// hvn_iter: shared iterative unit, floor square root (32 steps) or
// rounded division (30 quotient bits); depends on hvn_pkg
`default_nettype none

module hvn_iter import hvn_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire iter_cmd_t   cmd,
  output logic             done,
  output logic [31:0]      result
);

  logic        busy;
  logic        is_root;
  logic [5:0]  cnt;
  logic [63:0] x;
  logic [63:0] y;
  logic [63:0] z;
  logic [63:0] trial;
  logic        ge;

  // root: x = remainder, y = root, z = bit; divide: x = dividend, y = quotient, z = divisor
  assign trial  = is_root ? (y + z) : z;
  assign ge     = (x >= trial);
  assign result = y[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cmd.start && !busy) begin
        busy    <= 1'b1;
        is_root <= cmd.is_root;
        y       <= '0;
        if (cmd.is_root) begin
          x   <= cmd.opa;
          z   <= 64'h4000_0000_0000_0000;
          cnt <= 6'd31;
        end else begin
          // add half the divisor for round half up
          x   <= cmd.opa + {33'd0, cmd.opd[31:1]};
          z   <= {3'd0, cmd.opd, 29'd0};
          cnt <= 6'd29;
        end
      end else if (busy) begin
        if (ge) begin
          x <= x - trial;
        end
        if (is_root) begin
          y <= ge ? ((y >> 1) + z) : (y >> 1);
          z <= z >> 2;
        end else begin
          y <= {y[62:0], ge};
          z <= z >> 1;
        end
        if (cnt == 6'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 6'd1;
        end
      end
    end
  end

endmodule

`default_nettype wire

/* design/heightmap_vertex_normals.sv */
// heightmap_vertex_normals: streaming vertex normal generator, two line
// buffers, sequencer around one multiplier and one root/divide unit (hvn_iter)
//
//  channel   dir  handshake          payload
//  s_*       in   s_tvalid/s_tready  tdata: height_sample; tuser: cmd
//  m_*       out  m_tvalid/m_tready  tdata: normals, row, col; tlast: last_of_grid
//  cfg_*     in   cfg_we             cfg_index, cfg_data
//
// an item with no result goes through idle only; an item with a result runs
// the triangle steps once per triangle around the vertex (1 to 4), on the
// 32-step root and 30-step divides of the shared unit. the input is ready
// only in idle; a finished result waits in the output register while the
// next item is taken. rst is synchronous and clears control state only.
`default_nettype none

module heightmap_vertex_normals import hvn_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // height_sample
  input  wire logic        s_tuser,   // cmd
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [71:0]      m_tdata,   // normal_x, normal_y, normal_z, vertex_row, vertex_col, zero pad
  output logic             m_tlast,   // last_of_grid
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  hvn_state_t state, state_next;

  logic [CNT_W-1:0] grid_width;
  logic [CNT_W-1:0] grid_length;
  logic [15:0]      height_scale;
  logic [CNT_W-1:0] w_eff;
  logic [CNT_W-1:0] l_eff;

  logic [ROW_W-1:0] row_count;
  logic [COL_W-1:0] col_count;
  logic [COL_W-1:0] drain_col;
  logic             store_swap;
  logic             draining;

  logic [7:0]        mem [2*MAX_WIDTH];
  logic [7:0]        rdata;
  logic [MEM_AW-1:0] rd_addr;
  logic [MEM_AW-1:0] wr_addr;
  logic [7:0]        wr_data;
  logic              wr_en;

  logic             accept;
  logic             do_calc;
  logic [CNT_W-1:0] j_in;
  logic [CNT_W-1:0] j_next1;

  logic [COL_W-1:0] jcol;
  logic [ROW_W-1:0] vrow;
  logic             nbank;
  logic             wr_pending;
  logic             hl, hr, hu, hd, vlast;
  logic [7:0]       hc, vl, vr, vu, vd;
  logic [23:0]      dm [4];
  logic             ds [4];

  logic [2:0]  kcnt;
  logic [2:0]  tcnt;
  logic [31:0] len;
  logic [63:0] sacc;
  logic signed [31:0] acc0, acc1, acc2;
  logic [15:0] res0, res1, res2;

  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;

  logic        tri_en;
  logic        cxs, czs;
  logic [23:0] cxm, czm;
  logic [7:0]  nsel;
  logic [8:0]  diff;
  logic [7:0]  dmag;
  logic signed [31:0] csel;
  logic        csign;
  logic [31:0] cabs;

  iter_cmd_t   ucmd;
  logic        udone;
  logic [31:0] uresult;
  logic signed [31:0] qs;
  logic [14:0] qsat;

  logic [15:0] ox, oy, oz;
  logic [ROW_W-1:0] orow;
  logic [COL_W-1:0] ocol;
  logic        olast;

  hvn_iter u_iter (
    .clk    (clk),
    .rst    (rst),
    .cmd    (ucmd),
    .done   (udone),
    .result (uresult)
  );

  assign w_eff = (grid_width < CNT_W'(2)) ? CNT_W'(2) :
                 (grid_width > CNT_W'(MAX_WIDTH)) ? CNT_W'(MAX_WIDTH) : grid_width;
  assign l_eff = (grid_length < CNT_W'(2)) ? CNT_W'(2) :
                 (grid_length > CNT_W'(MAX_LENGTH)) ? CNT_W'(MAX_LENGTH) : grid_length;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    if (!s_tuser) begin
      j_in = ({1'b0, col_count} >= w_eff) ? (w_eff - CNT_W'(1)) : {1'b0, col_count};
    end else begin
      j_in = ({1'b0, drain_col} >= w_eff) ? (w_eff - CNT_W'(1)) : {1'b0, drain_col};
    end
    j_next1 = j_in + CNT_W'(1);
    do_calc = s_tuser ? draining : (!draining && (row_count != '0));
  end

  assign mul_p = mul_a * mul_b;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:       if (accept && do_calc) state_next = ST_READ;
      ST_READ:       if (kcnt == 3'd4) state_next = ST_DIFF;
      ST_DIFF:       if (kcnt == 3'd3) state_next = ST_TRI;
      ST_TRI: begin
        if (tcnt == 3'd4) state_next = ST_SUMSQ;
        else if (tri_en)  state_next = ST_SQ;
      end
      ST_SQ:         if (kcnt == 3'd1) state_next = ST_ROOT_GO;
      ST_ROOT_GO:    state_next = ST_ROOT_WAIT;
      ST_ROOT_WAIT:  if (udone) state_next = ST_DIV_GO;
      ST_DIV_GO:     state_next = ST_DIV_WAIT;
      ST_DIV_WAIT:   if (udone) state_next = (kcnt == 3'd2) ? ST_TRI : ST_DIV_GO;
      ST_SUMSQ:      if (kcnt == 3'd2) state_next = ST_ROOT2_GO;
      ST_ROOT2_GO:   state_next = ST_ROOT2_WAIT;
      ST_ROOT2_WAIT: if (udone) state_next = ST_DIV2_GO;
      ST_DIV2_GO:    state_next = ST_DIV2_WAIT;
      ST_DIV2_WAIT:  if (udone) state_next = (kcnt == 3'd2) ? ST_OUT : ST_DIV2_GO;
      ST_OUT:        if (!m_tvalid || m_tready) state_next = ST_IDLE;
      default:       state_next = ST_IDLE;
    endcase
  end

  // triangle operands: cx, cz as sign and magnitude; index 0 left, 1 right, 2 up, 3 down
  always_comb begin
    unique case (tcnt[1:0])
      2'd0: begin
        tri_en = hl && hd; cxs = ds[0];  cxm = dm[0]; czs = !ds[3]; czm = dm[3];
      end
      2'd1: begin
        tri_en = hd && hr; cxs = !ds[1]; cxm = dm[1]; czs = !ds[3]; czm = dm[3];
      end
      2'd2: begin
        tri_en = hr && hu; cxs = !ds[1]; cxm = dm[1]; czs = ds[2];  czm = dm[2];
      end
      default: begin
        tri_en = hu && hl; cxs = ds[0];  cxm = dm[0]; czs = ds[2];  czm = dm[2];
      end
    endcase
  end

  always_comb begin
    unique case (kcnt[1:0])
      2'd0:    nsel = vl;
      2'd1:    nsel = vr;
      2'd2:    nsel = vu;
      default: nsel = vd;
    endcase
    diff = {1'b0, nsel} - {1'b0, hc};
    dmag = diff[8] ? 8'(-diff) : diff[7:0];
    unique case (kcnt[1:0])
      2'd0:    begin csel = acc0; csign = acc0[31]; end
      2'd1:    begin csel = acc1; csign = acc1[31]; end
      default: begin csel = acc2; csign = !acc2[31]; end
    endcase
    cabs = csel[31] ? 32'(-csel) : csel;
  end

  // outputs of the sequencer: memory, multiplier and unit controls
  always_comb begin
    rd_addr = {nbank, jcol};
    wr_en   = 1'b0;
    wr_addr = {store_swap, j_in[COL_W-1:0]};
    wr_data = s_tdata;
    mul_a   = '0;
    mul_b   = '0;
    ucmd    = '0;
    ucmd.opd = len;
    unique case (state)
      ST_IDLE: begin
        // first row only fills the buffer
        wr_en = accept && !s_tuser && !draining && (row_count == '0);
      end
      ST_READ: begin
        unique case (kcnt)
          3'd0:    rd_addr = {nbank, jcol};
          3'd1:    rd_addr = {nbank, jcol - COL_W'(1)};
          3'd2:    rd_addr = {nbank, jcol + COL_W'(1)};
          default: rd_addr = {!nbank, jcol};
        endcase
        wr_en   = (kcnt == 3'd4) && wr_pending;
        wr_addr = {!nbank, jcol};
        wr_data = vd;
      end
      ST_DIFF: begin
        mul_a = {24'd0, dmag};
        mul_b = {16'd0, height_scale};
      end
      ST_SQ: begin
        mul_a = {8'd0, (kcnt == 3'd0) ? cxm : czm};
        mul_b = mul_a;
      end
      ST_SUMSQ: begin
        mul_a = cabs;
        mul_b = cabs;
      end
      ST_ROOT_GO: begin
        ucmd.start   = 1'b1;
        ucmd.is_root = 1'b1;
        ucmd.opa     = {sacc[51:0], 12'd0};
      end
      ST_ROOT2_GO: begin
        ucmd.start   = 1'b1;
        ucmd.is_root = 1'b1;
        ucmd.opa     = sacc;
      end
      ST_DIV_GO: begin
        ucmd.start = 1'b1;
        unique case (kcnt[1:0])
          2'd0:    ucmd.opa = {6'd0, cxm, 34'd0};
          2'd1:    ucmd.opa = 64'd1 << 50;
          default: ucmd.opa = {6'd0, czm, 34'd0};
        endcase
      end
      ST_DIV2_GO: begin
        ucmd.start = 1'b1;
        ucmd.opa   = {18'd0, cabs, 14'd0};
      end
      default: ;
    endcase
  end

  always_comb begin
    logic s;
    unique case (kcnt[1:0])
      2'd0:    s = cxs;
      2'd1:    s = 1'b0;
      default: s = czs;
    endcase
    qs   = s ? -$signed({1'b0, uresult[30:0]}) : $signed({1'b0, uresult[30:0]});
    qsat = (uresult > 32'd16384) ? 15'd16384 : uresult[14:0];
  end

  // line buffers
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata <= mem[rd_addr];
  end

  // control state and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      grid_width   <= CNT_W'(1024);
      grid_length  <= CNT_W'(1024);
      height_scale <= 16'd25600;
      row_count    <= '0;
      col_count    <= '0;
      drain_col    <= '0;
      store_swap   <= 1'b0;
      draining     <= 1'b0;
      kcnt         <= '0;
      tcnt         <= '0;
      m_tvalid     <= 1'b0;
    end else begin
      state <= state_next;

      if (accept) begin
        if (!s_tuser && !draining) begin
          if (j_next1 >= w_eff) begin
            col_count  <= '0;
            store_swap <= !store_swap;
            if ({1'b0, row_count} + CNT_W'(1) >= l_eff) begin
              draining  <= 1'b1;
              drain_col <= '0;
            end else begin
              row_count <= row_count + ROW_W'(1);
            end
          end else begin
            col_count <= j_next1[COL_W-1:0];
          end
        end else if (s_tuser && draining) begin
          if (j_next1 >= w_eff) begin
            drain_col <= '0;
            row_count <= '0;
            col_count <= '0;
            draining  <= 1'b0;
          end else begin
            drain_col <= j_next1[COL_W-1:0];
          end
        end
      end

      unique case (state)
        ST_READ, ST_DIFF, ST_SQ, ST_SUMSQ: begin
          kcnt <= (state_next == state) ? kcnt + 3'd1 : 3'd0;
        end
        ST_DIV_WAIT, ST_DIV2_WAIT: begin
          if (udone) kcnt <= (kcnt == 3'd2) ? 3'd0 : kcnt + 3'd1;
        end
        default: ;
      endcase

      if (state == ST_DIFF && kcnt == 3'd3) begin
        tcnt <= '0;
      end else if (state == ST_TRI && !tri_en && tcnt != 3'd4) begin
        tcnt <= tcnt + 3'd1;
      end else if (state == ST_DIV_WAIT && udone && kcnt == 3'd2) begin
        tcnt <= tcnt + 3'd1;
      end

      if (state == ST_OUT && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      if (cfg_we) begin
        unique case (cfg_index)
          REG_GRID_WIDTH, REG_GRID_LENGTH: begin
            if (cfg_index == REG_GRID_WIDTH) grid_width <= cfg_data[CNT_W-1:0];
            else                             grid_length <= cfg_data[CNT_W-1:0];
            row_count  <= '0;
            col_count  <= '0;
            drain_col  <= '0;
            store_swap <= 1'b0;
            draining   <= 1'b0;
          end
          REG_HEIGHT_SCALE: height_scale <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      jcol       <= j_in[COL_W-1:0];
      nbank      <= !store_swap;
      hl         <= (j_in != '0);
      hr         <= (j_next1 < w_eff);
      vd         <= s_tdata;
      wr_pending <= !s_tuser;
      if (!s_tuser) begin
        vrow  <= row_count - ROW_W'(1);
        hu    <= (row_count > ROW_W'(1));
        hd    <= 1'b1;
        vlast <= 1'b0;
      end else begin
        vrow  <= ROW_W'(l_eff - CNT_W'(1));
        hu    <= 1'b1;
        hd    <= 1'b0;
        vlast <= (j_next1 == w_eff);
      end
    end

    unique case (state)
      ST_READ: begin
        unique case (kcnt)
          3'd1: hc <= rdata;
          3'd2: vl <= rdata;
          3'd3: vr <= rdata;
          3'd4: vu <= rdata;
          default: ;
        endcase
      end
      ST_DIFF: begin
        dm[kcnt[1:0]] <= mul_p[23:0];
        ds[kcnt[1:0]] <= diff[8];
        if (kcnt == 3'd3) begin
          acc0 <= '0;
          acc1 <= '0;
          acc2 <= '0;
        end
      end
      ST_SQ: begin
        if (kcnt == 3'd0) sacc <= (64'd1 << 32) + mul_p;
        else              sacc <= sacc + mul_p;
      end
      ST_ROOT_WAIT, ST_ROOT2_WAIT: begin
        // length never falls to zero: y part is always present
        if (udone) len <= uresult;
      end
      ST_DIV_WAIT: begin
        if (udone) begin
          unique case (kcnt[1:0])
            2'd0:    acc0 <= acc0 + qs;
            2'd1:    acc1 <= acc1 + qs;
            default: acc2 <= acc2 + qs;
          endcase
        end
      end
      ST_SUMSQ: begin
        if (kcnt == 3'd0) sacc <= mul_p;
        else              sacc <= sacc + mul_p;
      end
      ST_DIV2_WAIT: begin
        if (udone) begin
          unique case (kcnt[1:0])
            2'd0:    res0 <= csign ? -{1'b0, qsat} : {1'b0, qsat};
            2'd1:    res1 <= csign ? -{1'b0, qsat} : {1'b0, qsat};
            default: res2 <= csign ? -{1'b0, qsat} : {1'b0, qsat};
          endcase
        end
      end
      default: ;
    endcase

    if (state == ST_OUT && (!m_tvalid || m_tready)) begin
      ox    <= res0;
      oy    <= res1;
      oz    <= res2;
      orow  <= vrow;
      ocol  <= jcol;
      olast <= vlast;
    end
  end

  assign m_tdata = {4'd0, 10'(ocol), 10'(orow), oz, oy, ox};
  assign m_tlast = olast;

endmodule

`default_nettype wire
